### sv/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types and constants of the program stream demultiplexer.
// ----------------------------------------------------------------------------
package psd_pkg;

   typedef enum logic [3:0] {
      PH_START,
      PH_PACK,
      PH_PACKSTUFF,
      PH_MAPLEN,
      PH_SKIP,
      PH_VHDR,
      PH_AHDR,
      PH_VOPT,
      PH_AOPT,
      PH_VPAY,
      PH_APAY
   } phase_type;

   typedef enum logic [1:0] {
      KIND_VIDEO = 2'd0,
      KIND_AUDIO = 2'd1,
      KIND_FEND  = 2'd2,
      KIND_ERROR = 2'd3
   } kind_type;

   localparam logic [7:0] SC_PACK       = 8'hBA;
   localparam logic [7:0] SC_SYS_HDR    = 8'hBB;
   localparam logic [7:0] SC_STREAM_MAP = 8'hBC;

   localparam logic [7:0] ERR_NO_START   = 8'd0;
   localparam logic [7:0] ERR_UNKNOWN_ID = 8'd1;

   localparam logic [7:0] VIDEO_ID_RESET = 8'hE0;
   localparam logic [7:0] AUDIO_ID_RESET = 8'hC0;

   localparam logic [0:0] CSR_VIDEO_ID = 1'b0;
   localparam logic [0:0] CSR_AUDIO_ID = 1'b1;

   localparam int TS_W = 27;

   // one front-end decision: optional frame end, then up to four bytes
   typedef struct packed {
      logic              fend;
      logic [TS_W-1:0]   fend_ts;
      logic [2:0]        cnt;
      logic [3:0][7:0]   bytes;
      kind_type          kind;
      logic [TS_W-1:0]   ts;
      logic              last;
   } cmd_type;

endpackage

### sv/program_stream_demux.sv
// ----------------------------------------------------------------------------
// program_stream_demux
// MPEG-2 program stream demultiplexer, one stream byte per item.
// ----------------------------------------------------------------------------
// The first result of a byte goes from the command queue through the sequencer
//   register to the result ports.
// Throughput: one byte per cycle while the queue is not full, one result per
//   cycle while popped; a byte that ends a video lookahead gives up to five
//   results, which the queue drains while the parser takes bytes until full.
// Reset (synchronous, active high) returns the parser to start-code hunting,
//   clears times, counters and queues, and loads the default stream ids.
// ----------------------------------------------------------------------------
module program_stream_demux #(
   parameter int CMD_DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   // byte stream in
   input  logic                     req_push,
   output logic                     req_full,
   input  logic [7:0]               req_data_byte,
   input  logic                     req_buffer_end,
   // results out
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic [1:0]               rsp_kind,
   output logic [7:0]               rsp_payload_byte,
   output logic [psd_pkg::TS_W-1:0] rsp_timestamp_ms,
   output logic                     rsp_last,
   // stream id registers
   input  logic                     csr_we,
   input  logic [0:0]               csr_index,
   input  logic [7:0]               csr_wdata
);
   import psd_pkg::*;

   cmd_type front_cmd;
   cmd_type head_cmd;
   logic    front_push;
   logic    fifo_pop;
   logic    fifo_empty;

   // front: parses headers, tracks PTS (divided by 90 as the bytes arrive)
   // and decides what each byte produces
   psd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_data_byte  (req_data_byte),
      .req_buffer_end (req_buffer_end),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .cmd_push       (front_push),
      .cmd            (front_cmd)
   );

   // queue of commands; a full queue stalls the byte input
   psd_cmd_fifo #(
      .DEPTH (CMD_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (front_push),
      .push_cmd (front_cmd),
      .full     (req_full),
      .pop      (fifo_pop),
      .head_cmd (head_cmd),
      .empty    (fifo_empty)
   );

   // back: walks each command, one result item per cycle while results are popped
   psd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_cmd         (head_cmd),
      .fifo_empty       (fifo_empty),
      .fifo_pop         (fifo_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_timestamp_ms (rsp_timestamp_ms),
      .rsp_last         (rsp_last)
   );

endmodule

### sv/psd_cmd_fifo.sv
// ----------------------------------------------------------------------------
// psd_cmd_fifo
// Short command queue between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module psd_cmd_fifo #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  psd_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output psd_pkg::cmd_type head_cmd,
   output logic             empty
);
   import psd_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type         mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop)) else $error("command queue overflow");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH)) else $error("command count out of range");

endmodule

### sv/psd_front.sv
// ----------------------------------------------------------------------------
// psd_front
// Byte parser: start codes, headers, PTS, payload classification.
// ----------------------------------------------------------------------------
module psd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  logic             req_full,
   input  logic [7:0]       req_data_byte,
   input  logic             req_buffer_end,
   input  logic             csr_we,
   input  logic [0:0]       csr_index,
   input  logic [7:0]       csr_wdata,
   output logic             cmd_push,
   output psd_pkg::cmd_type cmd
);
   import psd_pkg::*;

   // long division by 90, MSB first, n bits taken from the top of bits
   function automatic logic [TS_W+6:0] div90_step(input logic [TS_W-1:0] q,
                                                  input logic [6:0] r,
                                                  input logic [7:0] bits,
                                                  input logic [3:0] n);
      logic [7:0]      t;
      logic [TS_W-1:0] qq;
      logic [6:0]      rr;
      qq = q;
      rr = r;
      for (int i = 0; i < 8; i++) begin
         if (i < int'(n)) begin
            t = {rr, bits[7-i]};
            if (t >= 8'd90) begin
               t  = t - 8'd90;
               qq = {qq[TS_W-2:0], 1'b1};
            end else begin
               qq = {qq[TS_W-2:0], 1'b0};
            end
            rr = t[6:0];
         end
      end
      return {qq, rr};
   endfunction

   logic [7:0]       vid_id_ff, aud_id_ff;
   phase_type        phase_ff, phase_in;
   logic [7:0]       hpos_ff, hpos_in;
   logic [15:0]      rem_ff, rem_in;
   logic [7:0]       hdl_ff, hdl_in;
   logic [7:0]       flags_ff, flags_in;
   logic [TS_W-1:0]  ptsq_ff, ptsq_in;
   logic [6:0]       ptsr_ff, ptsr_in;
   logic [TS_W-1:0]  vtime_ff, vtime_in;
   logic [TS_W-1:0]  atime_ff, atime_in;
   logic [2:0]       fbc_ff, fbc_in;
   logic [3:0][7:0]  held_ff, held_in;
   logic [2:0]       hc_ff, hc_in;
   logic             disc_ff, disc_in;

   logic             acc;
   logic [7:0]       b;
   logic             pts_ok;
   logic [15:0]      dec;
   logic [7:0]       hpos_inc;
   logic [7:0]       dbits;
   logic [3:0]       dn;
   logic [TS_W+6:0]  dres;
   logic [2:0]       hc_new;
   logic [3:0][7:0]  bytes;
   logic [3:0]       fsum;
   logic [2:0]       fbase;
   logic [TS_W-1:0]  vt_new;

   assign acc    = req_push && !req_full;
   assign b      = req_data_byte;
   assign pts_ok = flags_ff[7] && (hdl_ff >= 8'd5);
   assign dec    = rem_ff - 16'd1;

   always_comb begin
      phase_in = phase_ff;
      hpos_in  = hpos_ff;
      rem_in   = rem_ff;
      hdl_in   = hdl_ff;
      flags_in = flags_ff;
      ptsq_in  = ptsq_ff;
      ptsr_in  = ptsr_ff;
      vtime_in = vtime_ff;
      atime_in = atime_ff;
      fbc_in   = fbc_ff;
      held_in  = held_ff;
      hc_in    = hc_ff;
      disc_in  = disc_ff;
      cmd      = '0;
      cmd.kind = KIND_VIDEO;
      hpos_inc = hpos_ff + 8'd1;
      dbits    = '0;
      dn       = '0;
      dres     = '0;
      hc_new   = hc_ff + 3'd1;
      bytes    = held_ff;
      fsum     = '0;
      fbase    = fbc_ff;
      vt_new   = vtime_ff;

      if (acc) begin
         if (disc_ff) begin
            if (req_buffer_end) begin
               disc_in  = 1'b0;
               phase_in = PH_START;
               hpos_in  = '0;
            end
         end else begin
            case (phase_ff)
               PH_START: begin
                  if (hpos_ff < 8'd3) begin
                     if (b != ((hpos_ff == 8'd2) ? 8'h01 : 8'h00)) begin
                        cmd.kind     = KIND_ERROR;
                        cmd.cnt      = 3'd1;
                        cmd.bytes[0] = ERR_NO_START;
                        hpos_in      = '0;
                        disc_in      = !req_buffer_end;
                     end else begin
                        hpos_in = hpos_inc;
                     end
                  end else begin
                     hpos_in = 8'd4;
                     if (b == SC_PACK) begin
                        phase_in = PH_PACK;
                     end else if (b == SC_SYS_HDR || b == SC_STREAM_MAP) begin
                        phase_in = PH_MAPLEN;
                     end else if (b == vid_id_ff) begin
                        phase_in = PH_VHDR;
                     end else if (b == aud_id_ff) begin
                        phase_in = PH_AHDR;
                     end else begin
                        cmd.kind     = KIND_ERROR;
                        cmd.cnt      = 3'd1;
                        cmd.bytes[0] = ERR_UNKNOWN_ID;
                        hpos_in      = '0;
                        disc_in      = !req_buffer_end;
                     end
                  end
               end
               PH_PACK: begin
                  if (hpos_ff < 8'd13) begin
                     hpos_in = hpos_inc;
                  end else begin
                     rem_in = {13'd0, b[2:0]};
                     if (b[2:0] == 3'd0) begin
                        phase_in = PH_START;
                        hpos_in  = '0;
                     end else begin
                        phase_in = PH_PACKSTUFF;
                     end
                  end
               end
               PH_PACKSTUFF, PH_SKIP: begin
                  rem_in = dec;
                  if (dec == 16'd0) begin
                     phase_in = PH_START;
                     hpos_in  = '0;
                  end
               end
               PH_MAPLEN: begin
                  if (hpos_ff == 8'd4) begin
                     rem_in  = {b, 8'h00};
                     hpos_in = 8'd5;
                  end else begin
                     rem_in = {rem_ff[15:8], b};
                     if ({rem_ff[15:8], b} == 16'd0) begin
                        phase_in = PH_START;
                        hpos_in  = '0;
                     end else begin
                        phase_in = PH_SKIP;
                     end
                  end
               end
               PH_VHDR, PH_AHDR: begin
                  if (hpos_ff == 8'd4) begin
                     rem_in  = {b, 8'h00};
                     hpos_in = 8'd5;
                  end else if (hpos_ff == 8'd5) begin
                     rem_in  = {rem_ff[15:8], b};
                     hpos_in = 8'd6;
                     if ({rem_ff[15:8], b} == 16'd0) begin
                        phase_in = PH_START;
                        hpos_in  = '0;
                     end
                  end else begin
                     rem_in = dec;
                     if (hpos_ff == 8'd7) begin
                        flags_in = b;
                     end
                     if (hpos_ff < 8'd8) begin
                        hpos_in = hpos_inc;
                        if (dec == 16'd0) begin
                           phase_in = PH_START;
                           hpos_in  = '0;
                        end
                     end else begin
                        hdl_in  = b;
                        ptsq_in = '0;
                        ptsr_in = '0;
                        if ({8'd0, b} > dec) begin
                           // header does not fit the packet: skip it
                           if (dec == 16'd0) begin
                              phase_in = PH_START;
                              hpos_in  = '0;
                           end else begin
                              phase_in = PH_SKIP;
                           end
                        end else begin
                           rem_in  = dec - {8'd0, b};
                           hpos_in = '0;
                           if (b == 8'd0) begin
                              // no optional header, so no PTS either
                              if (dec == 16'd0) begin
                                 phase_in = PH_START;
                              end else begin
                                 hc_in    = '0;
                                 phase_in = (phase_ff == PH_VHDR) ? PH_VPAY : PH_APAY;
                              end
                           end else begin
                              phase_in = (phase_ff == PH_VHDR) ? PH_VOPT : PH_AOPT;
                           end
                        end
                     end
                  end
               end
               PH_VOPT, PH_AOPT: begin
                  hpos_in = hpos_inc;
                  case (hpos_inc)
                     8'd1: begin
                        dbits = {b[3:1], 5'd0};
                        dn    = 4'd3;
                     end
                     8'd2, 8'd4: begin
                        dbits = b;
                        dn    = 4'd8;
                     end
                     8'd3, 8'd5: begin
                        dbits = {b[7:1], 1'b0};
                        dn    = 4'd7;
                     end
                     default: begin
                        dbits = '0;
                        dn    = 4'd0;
                     end
                  endcase
                  dres    = div90_step(ptsq_ff, ptsr_ff, dbits, dn);
                  ptsq_in = dres[TS_W+6:7];
                  ptsr_in = dres[6:0];
                  if (hpos_inc >= hdl_ff) begin
                     if (phase_ff == PH_AOPT && pts_ok) begin
                        atime_in = dres[TS_W+6:7];
                     end
                     if (rem_ff == 16'd0) begin
                        if (phase_ff == PH_VOPT && pts_ok) begin
                           vtime_in = dres[TS_W+6:7];
                        end
                        phase_in = PH_START;
                        hpos_in  = '0;
                     end else begin
                        hc_in    = '0;
                        phase_in = (phase_ff == PH_VOPT) ? PH_VPAY : PH_APAY;
                     end
                  end
               end
               PH_VPAY: begin
                  rem_in = dec;
                  if (hc_ff < 3'd4) begin
                     bytes[hc_ff[1:0]]   = b;
                     held_in[hc_ff[1:0]] = b;
                     hc_in               = hc_new;
                     if (hc_new == 3'd4 || dec == 16'd0) begin
                        if (hc_new == 3'd4 && fbc_ff > 3'd4 && bytes[0] == 8'h00 &&
                            bytes[1] == 8'h00 && bytes[2] == 8'h00 &&
                            bytes[3] == 8'h01) begin
                           cmd.fend    = 1'b1;
                           cmd.fend_ts = vtime_ff;
                           fbase       = '0;
                        end
                        if (pts_ok) begin
                           vt_new = ptsq_ff;
                        end
                        vtime_in  = vt_new;
                        cmd.kind  = KIND_VIDEO;
                        cmd.cnt   = hc_new;
                        cmd.bytes = bytes;
                        cmd.ts    = vt_new;
                        fsum      = {1'b0, fbase} + {1'b0, hc_new};
                        fbc_in    = (fsum > 4'd5) ? 3'd5 : fsum[2:0];
                        hc_in     = 3'd4;
                     end
                  end else begin
                     cmd.kind     = KIND_VIDEO;
                     cmd.cnt      = 3'd1;
                     cmd.bytes[0] = b;
                     cmd.ts       = vtime_ff;
                     fbc_in       = (fbc_ff < 3'd5) ? fbc_ff + 3'd1 : fbc_ff;
                  end
                  if (dec == 16'd0) begin
                     phase_in = PH_START;
                     hpos_in  = '0;
                  end
               end
               PH_APAY: begin
                  rem_in       = dec;
                  cmd.kind     = KIND_AUDIO;
                  cmd.cnt      = 3'd1;
                  cmd.bytes[0] = b;
                  cmd.ts       = atime_ff;
                  cmd.last     = (dec == 16'd0);
                  if (dec == 16'd0) begin
                     phase_in = PH_START;
                     hpos_in  = '0;
                  end
               end
               default: begin
                  phase_in = PH_START;
                  hpos_in  = '0;
               end
            endcase
         end
      end
   end

   // errors always force the parser back to hunting
   always_comb begin
      cmd_push = acc && (cmd.fend || cmd.cnt != 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vid_id_ff <= VIDEO_ID_RESET;
         aud_id_ff <= AUDIO_ID_RESET;
         phase_ff  <= PH_START;
         hpos_ff   <= '0;
         rem_ff    <= '0;
         hdl_ff    <= '0;
         flags_ff  <= '0;
         ptsq_ff   <= '0;
         ptsr_ff   <= '0;
         vtime_ff  <= '0;
         atime_ff  <= '0;
         fbc_ff    <= '0;
         hc_ff     <= '0;
         disc_ff   <= 1'b0;
      end else begin
         if (csr_we && csr_index == CSR_VIDEO_ID) begin
            vid_id_ff <= csr_wdata;
         end
         if (csr_we && csr_index == CSR_AUDIO_ID) begin
            aud_id_ff <= csr_wdata;
         end
         phase_ff <= (cmd_push && cmd.kind == KIND_ERROR) ? PH_START : phase_in;
         hpos_ff  <= hpos_in;
         rem_ff   <= rem_in;
         hdl_ff   <= hdl_in;
         flags_ff <= flags_in;
         ptsq_ff  <= ptsq_in;
         ptsr_ff  <= ptsr_in;
         vtime_ff <= vtime_in;
         atime_ff <= atime_in;
         fbc_ff   <= fbc_in;
         hc_ff    <= hc_in;
         disc_ff  <= disc_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

endmodule

### sv/psd_back.sv
// ----------------------------------------------------------------------------
// psd_back
// Result sequencer: expands one command into its result items.
// ----------------------------------------------------------------------------
module psd_back (
   input  logic                     clock,
   input  logic                     reset,
   input  psd_pkg::cmd_type         head_cmd,
   input  logic                     fifo_empty,
   output logic                     fifo_pop,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic [1:0]               rsp_kind,
   output logic [7:0]               rsp_payload_byte,
   output logic [psd_pkg::TS_W-1:0] rsp_timestamp_ms,
   output logic                     rsp_last
);
   import psd_pkg::*;

   cmd_type     cur_ff, cur_in;
   logic        valid_ff, valid_in;
   logic [2:0]  step_ff, step_in;
   logic [2:0]  total;
   logic [2:0]  idx;
   logic        take;
   logic        done;
   logic        load;

   assign total = cur_ff.cnt + {2'd0, cur_ff.fend};
   assign idx   = step_ff - {2'd0, cur_ff.fend};
   assign take  = valid_ff && rsp_pop;
   assign done  = take && (step_ff == total - 3'd1);
   assign load  = !valid_ff || done;

   assign fifo_pop  = load && !fifo_empty;
   assign rsp_empty = !valid_ff;

   always_comb begin
      cur_in   = cur_ff;
      valid_in = valid_ff;
      step_in  = step_ff;
      if (fifo_pop) begin
         cur_in   = head_cmd;
         valid_in = 1'b1;
         step_in  = '0;
      end else if (done) begin
         valid_in = 1'b0;
         step_in  = '0;
      end else if (take) begin
         step_in = step_ff + 3'd1;
      end
   end

   always_comb begin
      if (cur_ff.fend && step_ff == 3'd0) begin
         rsp_kind         = KIND_FEND;
         rsp_payload_byte = '0;
         rsp_timestamp_ms = cur_ff.fend_ts;
         rsp_last         = 1'b0;
      end else begin
         rsp_kind         = cur_ff.kind;
         rsp_payload_byte = cur_ff.bytes[idx[1:0]];
         rsp_timestamp_ms = cur_ff.ts;
         rsp_last         = cur_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (step_ff < total)) else $error("result step past command end");
   a_cmd_nonempty: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (total != 3'd0)) else $error("empty command in sequencer");

endmodule
